// ===== sv/framed_sample_moving_average_macros.svh =====
// assertion macros for the checker file of the moving average block
// no dependencies
`ifndef FRAMED_SAMPLE_MOVING_AVERAGE_MACROS_SVH
`define FRAMED_SAMPLE_MOVING_AVERAGE_MACROS_SVH

// checked only while reset is released
`define FSMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FSMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fsma_pkg.sv =====
// shared types and constants of the framed sample moving average block
// no dependencies
`default_nettype none

package fsma_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int BYTE_W         = 8;
    localparam int WINDOW_DEF     = 8;
    localparam int SYNC_ZEROS_DEF = 4;

    // register file
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam logic REG_DROP_NONNEG = 1'b0;

    // payload byte positions within the little-endian word
    localparam logic [1:0] POS_B0 = 2'd0;
    localparam logic [1:0] POS_B1 = 2'd1;
    localparam logic [1:0] POS_B3 = 2'd3;

    // sample handed from the framer to the window
    typedef struct packed {
        logic                push;
        logic [SAMPLE_W-1:0] sample;
    } t_word;

endpackage

`default_nettype wire

// ===== sv/fsma_framer.sv =====
// sync hunter and payload gatherer: finds the zero run, collects four bytes
// depends on fsma_pkg
`default_nettype none

module fsma_framer #(
    parameter int SYNC_ZEROS = fsma_pkg::SYNC_ZEROS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [fsma_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                        i_drop,
    output fsma_pkg::t_word                  o_word
);

    localparam int ZR_W = $clog2(SYNC_ZEROS + 1);

    typedef enum logic {
        HUNT,
        PAYLOAD
    } t_phase;

    t_phase                      r_phase;
    logic [ZR_W-1:0]             r_zero_run;
    logic [1:0]                  r_pos;
    logic [fsma_pkg::SAMPLE_W-1:0] r_lo;

    logic [ZR_W-1:0] n_zero_run;
    logic            w_last;

    assign n_zero_run = (i_byte == '0) ? r_zero_run + ZR_W'(1) : '0;
    assign w_last     = (r_phase == PAYLOAD) && (r_pos == fsma_pkg::POS_B3);

    // the sign bit of the word is bit 7 of the last byte
    assign o_word.push   = i_accept && w_last && (!i_drop || i_byte[fsma_pkg::BYTE_W-1]);
    assign o_word.sample = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= HUNT;
            r_zero_run <= '0;
            r_pos      <= '0;
        end else if (i_accept) begin
            case (r_phase)
                HUNT: begin
                    if (n_zero_run == ZR_W'(SYNC_ZEROS)) begin
                        r_zero_run <= '0;
                        r_pos      <= '0;
                        r_phase    <= PAYLOAD;
                    end else begin
                        r_zero_run <= n_zero_run;
                    end
                end
                PAYLOAD: begin
                    r_pos <= r_pos + 2'd1;
                    if (w_last) begin
                        r_phase <= HUNT;
                    end
                end
                default: r_phase <= HUNT;
            endcase
        end
    end

    // only the low half of the word reaches the samples
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == PAYLOAD) begin
            if (r_pos == fsma_pkg::POS_B0) begin
                r_lo[fsma_pkg::BYTE_W-1:0] <= i_byte;
            end
            if (r_pos == fsma_pkg::POS_B1) begin
                r_lo[fsma_pkg::SAMPLE_W-1:fsma_pkg::BYTE_W] <= i_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/fsma_cell.sv =====
// one sample cell of the window shift line
// depends on fsma_pkg
`default_nettype none

module fsma_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_shift,
    input  wire logic [fsma_pkg::SAMPLE_W-1:0] i_d,
    output logic      [fsma_pkg::SAMPLE_W-1:0] o_q
);

    logic [fsma_pkg::SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== sv/fsma_divider.sv =====
// signed divide of the running sum by the window, truncating toward zero,
// as an elastic pipeline ending in the output register; depends on fsma_pkg
`default_nettype none

module fsma_divider #(
    parameter int WINDOW = fsma_pkg::WINDOW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [fsma_pkg::SAMPLE_W-1:0] i_sum,
    output logic                               o_ready,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [fsma_pkg::SAMPLE_W-1:0] o_level
);

    localparam int SW     = fsma_pkg::SAMPLE_W;
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SHIFT  = SW + LOG_W;
    localparam int RECIP_I = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int RW     = SW + 1;
    localparam int PW     = SW + RW;
    localparam logic [RW-1:0] RECIP = RW'(RECIP_I);

    logic          r_v1, r_v2, r_v3, r_valid;
    logic [SW-1:0] r_sum1;
    logic          r_neg2, r_neg3;
    logic [SW-1:0] r_mag2, r_q3, r_level;

    logic    w_adv_o, w_adv3, w_adv2, w_adv1;
    logic [PW-1:0] w_prod;

    assign w_adv_o = !r_valid || i_ready;
    assign w_adv3  = !r_v3 || w_adv_o;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;

    // exact floor(mag / WINDOW) for any 16-bit magnitude
    assign w_prod = PW'(r_mag2) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_adv1)  r_v1    <= i_valid;
            if (w_adv2)  r_v2    <= r_v1;
            if (w_adv3)  r_v3    <= r_v2;
            if (w_adv_o) r_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_sum1 <= i_sum;
        end
        if (w_adv2) begin
            r_neg2 <= r_sum1[SW-1];
            r_mag2 <= r_sum1[SW-1] ? SW'(-r_sum1) : r_sum1;
        end
        if (w_adv3) begin
            r_neg3 <= r_neg2;
            r_q3   <= SW'(w_prod >> SHIFT);
        end
        if (w_adv_o) begin
            r_level <= r_neg3 ? SW'(-r_q3) : r_q3;
        end
    end

    assign o_valid = r_valid;
    assign o_level = r_level;

endmodule

`default_nettype wire

// ===== sv/framed_sample_moving_average.sv =====
// top level of the framed sample moving average block
// depends on fsma_pkg, fsma_framer, fsma_cell, fsma_divider
//
// usage
//   rx channel: one byte per request on i_rx_byte, i_rx_valid / o_rx_ready.
//   result channel: o_filtered_level, o_level_valid / i_level_ready; one
//   request for each kept word, the running sum over the window divided by
//   WINDOW, truncated toward zero.
//   a byte is taken every cycle while o_rx_ready is high; a result passes
//   the divider pipeline (r_sum1, r_mag2, r_q3, then output register r_level).
//   words are at least SYNC_ZEROS + 4 bytes apart, so results never limit
//   the byte rate while the receiver keeps up.
//   the samples move down a row of WINDOW cells; the oldest leaves the last
//   cell and is taken off the wrapping 16-bit sum.
//   apb register 0 (byte address 0): bit 0 drops words with the sign bit
//   clear. write only while idle.
//   reset (synchronous, active low) clears the framer, the cells, the sum,
//   the register and all valid flags at once; no clearing pass.
//   if the receiver stalls, results queue in the four pipeline stages; once
//   all are full o_rx_ready falls until the output request is taken.
`default_nettype none

module framed_sample_moving_average #(
    parameter int WINDOW     = fsma_pkg::WINDOW_DEF,
    parameter int SYNC_ZEROS = fsma_pkg::SYNC_ZEROS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rx_valid,
    output logic                               o_rx_ready,
    input  wire logic [fsma_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                               o_level_valid,
    input  wire logic                          i_level_ready,
    output logic      [fsma_pkg::SAMPLE_W-1:0] o_filtered_level,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fsma_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fsma_pkg::DATA_W-1:0]   pwdata,
    output logic      [fsma_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int SW = fsma_pkg::SAMPLE_W;

    logic            r_drop;
    logic [SW-1:0]   r_sum;
    logic [SW-1:0]   n_sum;
    logic            w_accept;
    logic            w_reg_sel;
    fsma_pkg::t_word w_word;
    logic [SW-1:0]   w_q [WINDOW];

    assign w_accept  = i_rx_valid && o_rx_ready;
    assign w_reg_sel = (paddr[fsma_pkg::ADDR_W-1] == fsma_pkg::REG_DROP_NONNEG);

    // register port
    assign pready = 1'b1;
    assign prdata = w_reg_sel ? fsma_pkg::DATA_W'(r_drop) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_drop <= pwdata[0];
        end
    end

    fsma_framer #(
        .SYNC_ZEROS(SYNC_ZEROS)
    ) u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_byte  (i_rx_byte),
        .i_drop  (r_drop),
        .o_word  (w_word)
    );

    // window shift line, newest sample in cell 0
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        if (k == 0) begin : g_head
            fsma_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(w_word.push),
                .i_d    (w_word.sample),
                .o_q    (w_q[k])
            );
        end else begin : g_body
            fsma_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(w_word.push),
                .i_d    (w_q[k-1]),
                .o_q    (w_q[k])
            );
        end
    end

    assign n_sum = r_sum - w_q[WINDOW-1] + w_word.sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (w_word.push) begin
            r_sum <= n_sum;
        end
    end

    fsma_divider #(
        .WINDOW(WINDOW)
    ) u_divider (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_word.push),
        .i_sum  (n_sum),
        .o_ready(o_rx_ready),
        .o_valid(o_level_valid),
        .i_ready(i_level_ready),
        .o_level(o_filtered_level)
    );

endmodule

`default_nettype wire

// ===== sv/fsma_checker.sv =====
// port-level checks of the framed sample moving average block, and the bind
// depends on fsma_pkg and framed_sample_moving_average_macros.svh
`default_nettype none
`include "framed_sample_moving_average_macros.svh"

module fsma_port_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_rx_ready,
    input wire logic                          o_level_valid,
    input wire logic                          i_level_ready,
    input wire logic [fsma_pkg::SAMPLE_W-1:0] o_filtered_level,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [fsma_pkg::ADDR_W-1:0]   paddr,
    input wire logic [fsma_pkg::DATA_W-1:0]   pwdata,
    input wire logic [fsma_pkg::DATA_W-1:0]   prdata,
    input wire logic                          pready
);

    // a stalled result request holds
    `FSMA_ASSERT(a_out_hold, i_clk, i_rst_n, o_level_valid && !i_level_ready |=> o_level_valid && $stable(o_filtered_level), "result changed while stalled")

    // bytes are refused only when the output holds a result and the receiver stalls
    `FSMA_ASSERT(a_ready_low, i_clk, i_rst_n, !o_rx_ready |-> o_level_valid && !i_level_ready, "rx stalled without a full pipeline")

    // nothing leaves right after reset
    `FSMA_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_level_valid, "result valid after reset")

    // a register write reads back
    `FSMA_ASSERT(a_readback, i_clk, i_rst_n, psel && penable && pwrite && pready && !paddr[fsma_pkg::ADDR_W-1] |=> paddr[fsma_pkg::ADDR_W-1] || prdata[0] == $past(pwdata[0]), "register readback mismatch")

endmodule

bind framed_sample_moving_average fsma_port_checker u_fsma_checker (.*);

`default_nettype wire
